FILE: rtl/idt_pkg.sv
// Shared types, character codes and helpers for the inline delimiter tokenizer.
`timescale 1ns / 1ps

package idt_pkg;

  // Default width of source offsets.
  localparam int POSITION_BITS_DEF = 16;

  // Fixed field widths of the channels.
  localparam int CH_W   = 8;
  localparam int POS_W  = 16;
  localparam int LEN_W  = 16;
  localparam int KIND_W = 3;

  // Delimiter and whitespace bytes.
  localparam logic [CH_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [CH_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [CH_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [CH_W-1:0] CH_LBRACK = 8'h5B;
  localparam logic [CH_W-1:0] CH_RBRACK = 8'h5D;
  localparam logic [CH_W-1:0] CH_SLASH  = 8'h2F;
  localparam logic [CH_W-1:0] CH_BSLASH = 8'h5C;
  localparam logic [CH_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CH_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CH_W-1:0] CH_LF     = 8'h0A;
  localparam logic [CH_W-1:0] CH_VT     = 8'h0B;
  localparam logic [CH_W-1:0] CH_FF     = 8'h0C;
  localparam logic [CH_W-1:0] CH_CR     = 8'h0D;

  typedef enum logic [KIND_W-1:0] {
    KIND_EMPH    = 3'd0,
    KIND_STRONG  = 3'd1,
    KIND_PAREN   = 3'd2,
    KIND_REF     = 3'd3,
    KIND_COMMENT = 3'd4
  } kind_t;

  // Lookahead held between bytes.
  typedef enum logic [1:0] {
    PEND_NONE  = 2'd0,
    PEND_STAR  = 2'd1,
    PEND_SLASH = 2'd2
  } pend_t;

  // Comment progress within a line.
  typedef enum logic [1:0] {
    CMT_NONE  = 2'd0,
    CMT_SPACE = 2'd1,
    CMT_DONE  = 2'd2
  } cmt_t;

  typedef struct packed {
    kind_t             kind;
    logic              opening;
    logic [POS_W-1:0]  start_res;
    logic [LEN_W-1:0]  length;
    logic              last_of_run;
  } res_t;

  function automatic logic is_space(input logic [CH_W-1:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
           (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
  endfunction

endpackage

FILE: rtl/idt_in_if.sv
// Input byte channel of the inline delimiter tokenizer.
`timescale 1ns / 1ps

interface idt_in_if
  import idt_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CH_W-1:0]   ch;
  logic [POS_W-1:0]  pos;
  logic              line_start;
  logic              line_end;
  logic              parens_enabled;

  modport source (output valid, ch, pos, line_start, line_end, parens_enabled,
                  input ready);
  modport sink   (input valid, ch, pos, line_start, line_end, parens_enabled,
                  output ready);
endinterface

FILE: rtl/idt_out_if.sv
// Token result channel of the inline delimiter tokenizer.
`timescale 1ns / 1ps

interface idt_out_if
  import idt_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic               opening;
  logic [POS_W-1:0]   start_res;
  logic [LEN_W-1:0]   length;
  logic               last_of_run;

  modport source (output valid, kind, opening, start_res, length, last_of_run,
                  input ready);
  modport sink   (input valid, kind, opening, start_res, length, last_of_run,
                  output ready);
endinterface

FILE: rtl/inline_delimiter_tokenizer_unit.sv
// Top level of the inline delimiter tokenizer: byte decode, lookahead state, token queue.
// Each token is written into the queue as its byte transfers and is offered after older tokens.
// Throughput: one byte per cycle while the output is not stalled and each byte yields at most
// one token; a byte that yields two tokens uses the single output port for both in turn.
// Reset: rst_n is synchronous, active low; it clears the lookahead, comment state and queue.
`timescale 1ns / 1ps

module inline_delimiter_tokenizer_unit
  import idt_pkg::*;
#(
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  idt_in_if.sink     in_bus,
  idt_out_if.source  out_bus
);

  // Offsets are kept at the narrower of the configured width and the port width.
  localparam int PW = (POSITION_BITS < POS_W) ? POSITION_BITS : POS_W;

  // The result queue holds three tokens. A byte is taken only while two slots are
  // free, so the ready decision never depends on the output side in the same cycle.
  localparam int QDEPTH = 3;
  localparam int QPW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // Per-line scanning state.
  logic [CH_W-1:0] prev_r;
  pend_t           pend_r, pend_nxt;
  cmt_t            cmt_r, cmt_nxt;
  logic [PW-1:0]   ps_r, ps_nxt;

  // Token queue.
  res_t            q_mem [QDEPTH];
  logic [QPW-1:0]  wp_r, rp_r;
  logic [QCW-1:0]  cnt_r, cnt_nxt;

  logic            in_fire, out_fire;
  logic [CH_W-1:0] c;
  logic [PW-1:0]   pos_m;
  logic            ls, le, pe;
  pend_t           pend_e;
  cmt_t            cmt_e;
  logic            esc, sp, done;
  logic [PW-1:0]   cmt_len_here, cmt_len_end;

  res_t            tok_a, tok_b, tok0, tok1;
  logic            a_vld, b_vld;
  logic [1:0]      npush;
  logic [QPW-1:0]  wp_p1;

  function automatic logic [QPW-1:0] q_inc(input logic [QPW-1:0] p);
    return (p == QPW'(QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign c     = in_bus.ch;
  assign pos_m = in_bus.pos[PW-1:0];
  assign ls    = in_bus.line_start;
  assign le    = in_bus.line_end;
  assign pe    = in_bus.parens_enabled;

  assign in_bus.ready = (cnt_r <= QCW'(QDEPTH - 2));
  assign in_fire      = in_bus.valid && in_bus.ready;
  assign out_fire     = out_bus.valid && out_bus.ready;

  // A line start wipes the state before the byte is looked at, so the first byte of a
  // region never sees an escape or a stale lookahead.
  assign pend_e = ls ? PEND_NONE : pend_r;
  assign cmt_e  = ls ? CMT_NONE : cmt_r;
  assign esc    = !ls && (prev_r == CH_BSLASH);
  assign sp     = is_space(c);

  // The byte is consumed by the lookahead or comment logic and is not decoded itself
  // when a comment is running, or when it completes a star pair or a slash pair.
  assign done = (cmt_e != CMT_NONE) ||
                ((pend_e == PEND_STAR) && (c == CH_STAR)) ||
                ((pend_e == PEND_SLASH) && (c == CH_SLASH));

  // The comment covers both slashes and the whitespace after them. It ends at the first
  // non-space byte, or includes the final byte when the line runs out first.
  assign cmt_len_here = pos_m - ps_r;
  assign cmt_len_end  = pos_m + PW'(1) - ps_r;

  // Next-state logic for the lookahead and comment tracking.
  always_comb begin
    pend_nxt = pend_e;
    cmt_nxt  = cmt_e;
    ps_nxt   = ps_r;
    unique case (cmt_e)
      CMT_DONE: begin
      end
      CMT_SPACE: begin
        if (!sp || le) begin
          cmt_nxt = CMT_DONE;
        end
      end
      CMT_NONE: begin
        unique case (pend_e)
          PEND_STAR: begin
            pend_nxt = PEND_NONE;
          end
          PEND_SLASH: begin
            pend_nxt = PEND_NONE;
            if (c == CH_SLASH) begin
              cmt_nxt = le ? CMT_DONE : CMT_SPACE;
            end
          end
          PEND_NONE: begin
          end
          default: begin
            pend_nxt = PEND_NONE;
          end
        endcase
      end
      default: begin
        cmt_nxt = CMT_NONE;
      end
    endcase
    // A star or slash mid-line waits one byte to see whether it pairs up.
    if (!done && !esc && !le) begin
      if (c == CH_STAR) begin
        pend_nxt = PEND_STAR;
        ps_nxt   = pos_m;
      end else if (c == CH_SLASH) begin
        pend_nxt = PEND_SLASH;
        ps_nxt   = pos_m;
      end
    end
    // Nothing carries past the end of a line.
    if (le) begin
      pend_nxt = PEND_NONE;
      cmt_nxt  = CMT_NONE;
    end
  end

  // Token generation: token A comes from the held state, token B from the byte itself.
  always_comb begin
    tok_a         = '0;
    tok_a.opening = 1'b1;
    a_vld         = 1'b0;
    tok_b         = '0;
    b_vld         = 1'b0;

    unique case (cmt_e)
      CMT_DONE: begin
      end
      CMT_SPACE: begin
        if (!sp || le) begin
          a_vld           = 1'b1;
          tok_a.kind      = KIND_COMMENT;
          tok_a.start_res = POS_W'(ps_r);
          tok_a.length    = sp ? LEN_W'(cmt_len_end) : LEN_W'(cmt_len_here);
        end
      end
      CMT_NONE: begin
        unique case (pend_e)
          PEND_STAR: begin
            // A waiting star is strong if this byte is a star, otherwise emphasis.
            a_vld           = 1'b1;
            tok_a.start_res = POS_W'(ps_r);
            if (c == CH_STAR) begin
              tok_a.kind   = KIND_STRONG;
              tok_a.length = LEN_W'(2);
            end else begin
              tok_a.kind   = KIND_EMPH;
              tok_a.length = LEN_W'(1);
            end
          end
          PEND_SLASH: begin
            // A double slash closing the line is a two-byte comment right away.
            if ((c == CH_SLASH) && le) begin
              a_vld           = 1'b1;
              tok_a.kind      = KIND_COMMENT;
              tok_a.start_res = POS_W'(ps_r);
              tok_a.length    = LEN_W'(2);
            end
          end
          PEND_NONE: begin
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase

    tok_b.start_res = POS_W'(pos_m);
    tok_b.length    = LEN_W'(1);
    tok_b.opening   = 1'b1;
    tok_b.kind      = KIND_EMPH;
    if (!done && !esc) begin
      unique case (c)
        CH_STAR: begin
          // A lone star on the last byte cannot pair up, so it is emphasis now.
          b_vld      = le;
          tok_b.kind = KIND_EMPH;
        end
        CH_LPAREN: begin
          b_vld      = pe;
          tok_b.kind = KIND_PAREN;
        end
        CH_RPAREN: begin
          b_vld         = pe;
          tok_b.kind    = KIND_PAREN;
          tok_b.opening = 1'b0;
        end
        CH_LBRACK: begin
          b_vld      = 1'b1;
          tok_b.kind = KIND_REF;
        end
        CH_RBRACK: begin
          b_vld         = 1'b1;
          tok_b.kind    = KIND_REF;
          tok_b.opening = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // Pack the tokens of this byte in order and mark the final one.
  always_comb begin
    tok0  = a_vld ? tok_a : tok_b;
    tok1  = tok_b;
    npush = 2'(a_vld) + 2'(b_vld);
    tok0.last_of_run = (npush == 2'd1);
    tok1.last_of_run = 1'b1;
  end

  assign wp_p1 = q_inc(wp_r);

  always_comb begin
    cnt_nxt = cnt_r;
    if (in_fire) begin
      cnt_nxt = cnt_nxt + QCW'(npush);
    end
    if (out_fire) begin
      cnt_nxt = cnt_nxt - 1'b1;
    end
  end

  // Scanning state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
      pend_r <= PEND_NONE;
      cmt_r  <= CMT_NONE;
    end else if (in_fire) begin
      prev_r <= c;
      pend_r <= pend_nxt;
      cmt_r  <= cmt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      ps_r <= ps_nxt;
    end
  end

  // Queue pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (in_fire) begin
        if (npush == 2'd1) begin
          wp_r <= wp_p1;
        end else if (npush == 2'd2) begin
          wp_r <= q_inc(wp_p1);
        end
      end
      if (out_fire) begin
        rp_r <= q_inc(rp_r);
      end
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (in_fire && (npush != 2'd0)) begin
      q_mem[wp_r] <= tok0;
    end
    if (in_fire && (npush == 2'd2)) begin
      q_mem[wp_p1] <= tok1;
    end
  end

  assign out_bus.valid       = (cnt_r != '0);
  assign out_bus.kind        = q_mem[rp_r].kind;
  assign out_bus.opening     = q_mem[rp_r].opening;
  assign out_bus.start_res   = q_mem[rp_r].start_res;
  assign out_bus.length      = q_mem[rp_r].length;
  assign out_bus.last_of_run = q_mem[rp_r].last_of_run;

`ifndef NO_ASSERTIONS
  // A transfer never pushes more tokens than the queue has room for.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> ((cnt_r + QCW'(npush)) <= QCW'(QDEPTH)))
    else $error("token queue overflow");

  // After the last byte of a line no lookahead or comment state survives.
  a_line_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && le |=> (pend_r == PEND_NONE) && (cmt_r == CMT_NONE))
    else $error("state kept past line end");

  // Once the comment is emitted, the rest of the line yields no tokens.
  a_comment_silences: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !ls && (cmt_r == CMT_DONE) |-> (npush == 2'd0))
    else $error("token after finished comment");

  // A pop with no byte transferred lowers the fill level by one.
  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && !in_fire |=> (cnt_r == $past(cnt_r) - 1'b1))
    else $error("queue count mismatch");
`endif

endmodule
